// File: rtl/gdbd_pkg.sv
// ----------------------------------------------------------------------------
// gdbd_pkg: shared types, constants and calendar tables
// Widths of the date fields, the valid year range, the reciprocal used for
// division by one hundred and the month tables used by the date unit.
// ----------------------------------------------------------------------------
package gdbd_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 12;
	localparam int DOY_W   = 9;
	localparam int DNUM_W  = 21;
	localparam int COUNT_W = 18;

	localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd1600;
	localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2100;

	// floor(x / 100) = (x * 5243) >> 19 for every x below 8192.
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SH  = 19;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Load enables for the three stages of a date unit.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	// Days in the given month, February from the leap flag; 0 for a bad month.
	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days of a common year that come before the first of the given month.
	function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] n;
		case (m)
			4'd1:  n = 9'd0;
			4'd2:  n = 9'd31;
			4'd3:  n = 9'd59;
			4'd4:  n = 9'd90;
			4'd5:  n = 9'd120;
			4'd6:  n = 9'd151;
			4'd7:  n = 9'd181;
			4'd8:  n = 9'd212;
			4'd9:  n = 9'd243;
			4'd10: n = 9'd273;
			4'd11: n = 9'd304;
			4'd12: n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/gdbd_date_unit.sv
// ----------------------------------------------------------------------------
// gdbd_date_unit: day number of one date
// Three register stages turn a day, month and year into the count of days
// since the start of year 0 and a flag for a date that fails its check.
// ----------------------------------------------------------------------------
module gdbd_date_unit
	import gdbd_pkg::*;
(
	input  logic               clk,
	input  stage_en_t          en,
	input  logic [DAY_W-1:0]   day,
	input  logic [MONTH_W-1:0] month,
	input  logic [YEAR_W-1:0]  year,
	output logic [DNUM_W-1:0]  day_num,
	output logic               bad
);

	// Stage 1: the products for the whole-year count and the century quotient.
	logic [12:0] y99;
	logic [12:0] y399;
	logic [25:0] p100;
	logic [25:0] p400;
	logic [25:0] pq;
	logic [DNUM_W-1:0] y365;

	assign y99  = {1'b0, year} + 13'd99;
	assign y399 = {1'b0, year} + 13'd399;
	assign p100 = 26'(y99) * 26'(RECIP_100);
	assign p400 = 26'({2'b00, y399[12:2]}) * 26'(RECIP_100);
	assign pq   = 26'({1'b0, year}) * 26'(RECIP_100);
	assign y365 = DNUM_W'({9'd0, year}) * DNUM_W'(365);

	logic [DAY_W-1:0]   day_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [DNUM_W-1:0]  y365_s1;
	logic [5:0]         c100_s1;
	logic [3:0]         c400_s1;
	logic [5:0]         q100_s1;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
			y365_s1  <= y365;
			c100_s1  <= p100[RECIP_SH+5:RECIP_SH];
			c400_s1  <= p400[RECIP_SH+3:RECIP_SH];
			q100_s1  <= pq[RECIP_SH+5:RECIP_SH];
		end
	end

	// Stage 2: leap year, date check, day of year and whole-year day count.
	logic [12:0]       cent;
	logic              leap;
	logic [DAY_W-1:0]  len;
	logic              ok;
	logic [10:0]       c4;
	logic [DOY_W-1:0]  doy;
	logic [DNUM_W-1:0] dby;

	always_comb begin
		cent = 13'(q100_s1) * 13'd100;
		leap = (year_s1[1:0] == 2'b00) &&
			(({1'b0, year_s1} != cent) || (q100_s1[1:0] == 2'b00));
		len  = month_days(month_s1, leap);
		ok   = (year_s1 >= YEAR_MIN) && (year_s1 <= YEAR_MAX) && (len != '0) &&
			(day_s1 != '0) && (day_s1 <= len);
		c4   = 11'(({1'b0, year_s1} + 13'd3) >> 2);
		doy  = days_before_month(month_s1) + DOY_W'(day_s1) +
			DOY_W'(leap && (month_s1 > 4'd2));
		dby  = y365_s1 + DNUM_W'(c4) - DNUM_W'(c100_s1) + DNUM_W'(c400_s1);
	end

	logic [DOY_W-1:0]  doy_s2;
	logic [DNUM_W-1:0] dby_s2;
	logic              bad_s2;

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			doy_s2 <= ok ? doy : '0;
			dby_s2 <= dby;
			bad_s2 <= !ok;
		end
	end

	// Stage 3: the day number itself.
	logic [DNUM_W-1:0] dnum_s3;
	logic              bad_s3;

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			dnum_s3 <= dby_s2 + DNUM_W'(doy_s2);
			bad_s3  <= bad_s2;
		end
	end

	assign day_num = dnum_s3;
	assign bad     = bad_s3;

endmodule

// File: rtl/gregorian_days_between_dates.sv
// ----------------------------------------------------------------------------
// gregorian_days_between_dates: days between two Gregorian dates
// Two date units produce day numbers; a last stage takes the magnitude of
// their difference, saturates it and flags a date that failed its check.
// ----------------------------------------------------------------------------
// A pair of dates is taken in every cycle in which in_stall is low and passes
// through the four register stages (products, date check and year sums, day
// number, difference). A stall on the output holds each stage that has no room
// ahead of it; empty stages keep filling, so no beat is lost.
module gregorian_days_between_dates
	import gdbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [DAY_W-1:0]   first_day,
	input  logic [MONTH_W-1:0] first_month,
	input  logic [YEAR_W-1:0]  first_year,
	input  logic [DAY_W-1:0]   second_day,
	input  logic [MONTH_W-1:0] second_month,
	input  logic [YEAR_W-1:0]  second_year,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COUNT_W-1:0] day_count,
	output logic               invalid_date
);

	// Valid bits of the stages and their load enables.
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	stage_en_t en;

	assign rdy4 = !v_s4 || !out_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign en   = '{en_s1: rdy1, en_s2: rdy2, en_s3: rdy3};
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// The two date units.
	logic [DNUM_W-1:0] num_a, num_b;
	logic              bad_a, bad_b;

	gdbd_date_unit u_first (
		.clk     (clk),
		.en      (en),
		.day     (first_day),
		.month   (first_month),
		.year    (first_year),
		.day_num (num_a),
		.bad     (bad_a)
	);

	gdbd_date_unit u_second (
		.clk     (clk),
		.en      (en),
		.day     (second_day),
		.month   (second_month),
		.year    (second_year),
		.day_num (num_b),
		.bad     (bad_b)
	);

	// Stage 4: magnitude of the difference, saturated to the output width.
	logic [DNUM_W-1:0] diff;

	assign diff = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);

	logic [COUNT_W-1:0] count_s4;
	logic               bad_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			count_s4 <= (diff > DNUM_W'(COUNT_MAX)) ? COUNT_MAX : diff[COUNT_W-1:0];
			bad_s4   <= bad_a || bad_b;
		end
	end

	assign out_valid    = v_s4;
	assign day_count    = count_s4;
	assign invalid_date = bad_s4;

`ifndef SYNTH
	// Two valid dates between 1600 and 2100 are never more than 183000 days apart.
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !invalid_date |-> day_count <= COUNT_W'(183000))
		else $error("day count out of range for valid dates");

	// An empty first stage never stalls the input.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with first stage empty");

	// A blocked beat in the third stage is still there in the next cycle.
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !rdy4 |=> v_s3)
		else $error("beat lost in third stage");
`endif

endmodule
